FILE: hw/rtl/tgarle_pkg.sv
// Shared types, constants and helpers for the TGA pixel-data decoder.
`default_nettype none

package tgarle_pkg;

    // Packet header layout.
    localparam int unsigned MAX_PACKET  = 128;
    localparam int unsigned HDR_RUN_BIT = 7;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned ACCUM_W  = 24;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned ROWS_W   = 17;
    localparam int unsigned REMAIN_W = 32;
    localparam int unsigned POS_W    = 33;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Output beat layout.
    localparam int unsigned OUT_DATA_W = PIXEL_W + COUNT_W + 2 * COORD_W;

    // Serial divider used to fold a column offset back into row and column.
    localparam int unsigned DIV_STEPS = ROWS_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RLE_ENABLED     = 3'd0,
        CFG_PIXEL_FORMAT    = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_TOP_LEFT_ORIGIN = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        FMT_ONE_BYTE   = 2'd0,
        FMT_THREE_BYTE = 2'd1,
        FMT_FOUR_BYTE  = 2'd2
    } t_pixel_format;

    // Remaining-pixel recompute after a register write.
    typedef enum logic [1:0] {
        RC_IDLE,
        RC_MUL,
        RC_SUB
    } t_recalc_state;

    typedef struct packed {
        logic               start;
        logic [ROWS_W-1:0]  dividend;
        logic [COORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ROWS_W-1:0]  quotient;
        logic [COORD_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_ONE_BYTE:   n = 3'd1;
            FMT_THREE_BYTE: n = 3'd3;
            default:        n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA pixel-data decoder: byte stream in, pixel groups out.
// Bytes wait in the input register; the group a byte completes goes to the output register.
// Throughput: one byte per cycle unless output stalls; a group that moves the position more
// than one row ahead stalls input while the serial divider folds the column back into range.
// A register write stalls input while the remaining pixel count is recomputed.
// Synchronous active-low reset restores register defaults and waits for a packet header.
`default_nettype none

module tga_rle_pixel_decoder_unit
    import tgarle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream. tdata: data_byte[7:0].
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]     i_s_axis_tdata,
    // Output stream. tdata: pixel_value[31:0], repeat_count[39:32],
    // start_column[55:40], start_row[71:56]. tlast: image_done.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    // Register writes.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic               r_rle;
    logic [1:0]         r_fmt;
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic               r_top;

    // Decode state.
    logic                r_expect_hdr, n_expect_hdr;
    logic                r_run,        n_run;
    logic [COUNT_W-1:0]  r_pix_left,   n_pix_left;
    logic [1:0]          r_byte_pos,   n_byte_pos;
    logic [ACCUM_W-1:0]  r_accum,      n_accum;
    logic [COORD_W-1:0]  r_col,        n_col;
    logic [ROWS_W-1:0]   r_rows,       n_rows;
    logic                r_finished,   n_finished;
    logic [REMAIN_W-1:0] r_remaining,  n_remaining;

    // Input and output registers.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid,  n_out_valid;
    logic [PIXEL_W-1:0] r_out_pixel,  n_out_pixel;
    logic [COUNT_W-1:0] r_out_count,  n_out_count;
    logic [COORD_W-1:0] r_out_col,    n_out_col;
    logic [COORD_W-1:0] r_out_row,    n_out_row;
    logic               r_out_last,   n_out_last;
    logic               n_out_load;

    // Recompute of the remaining pixel count.
    t_recalc_state       r_rc_state, n_rc_state;
    logic                rc_mul_en;
    logic                rc_sub_en;
    logic [POS_W-1:0]    r_prod_pos;
    logic [REMAIN_W-1:0] r_prod_total;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic cfg_fire;
    logic in_fire;
    logic proc;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    assign proc = r_in_valid && (r_rc_state == RC_IDLE) && !div_rsp.busy
                  && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    tgarle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Recompute FSM: multiply, then subtract; a new write restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_state <= RC_IDLE;
        end else begin
            r_rc_state <= n_rc_state;
        end
    end

    always_comb begin
        n_rc_state = r_rc_state;
        rc_mul_en  = 1'b0;
        rc_sub_en  = 1'b0;
        unique case (r_rc_state)
            RC_IDLE: begin
                if (cfg_fire) begin
                    n_rc_state = RC_MUL;
                end
            end
            RC_MUL: begin
                if (cfg_fire) begin
                    n_rc_state = RC_MUL;
                end else if (!div_rsp.busy) begin
                    rc_mul_en  = 1'b1;
                    n_rc_state = RC_SUB;
                end
            end
            RC_SUB: begin
                if (cfg_fire) begin
                    n_rc_state = RC_MUL;
                end else begin
                    rc_sub_en  = 1'b1;
                    n_rc_state = RC_IDLE;
                end
            end
            default: n_rc_state = RC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rc_mul_en) begin
            r_prod_pos   <= POS_W'(r_rows * r_width);
            r_prod_total <= REMAIN_W'(r_width * r_height);
        end
    end

    // Per-byte decode.
    logic [2:0]         nbytes;
    logic [4:0]         shamt;
    logic [PIXEL_W-1:0] pix_value;
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] count;
    logic [ROWS_W-1:0]  col_sum;
    logic [ROWS_W-1:0]  col_wrap;
    logic               fits_row;
    logic               fits_next;
    logic [POS_W-1:0]   lin_pos;
    logic [POS_W-1:0]   total_ext;

    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_run        = r_run;
        n_pix_left   = r_pix_left;
        n_byte_pos   = r_byte_pos;
        n_accum      = r_accum;
        n_col        = r_col;
        n_rows       = r_rows;
        n_finished   = r_finished;
        n_remaining  = r_remaining;
        n_out_load   = 1'b0;
        n_out_pixel  = r_out_pixel;
        n_out_count  = r_out_count;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_out_last   = r_out_last;
        div_req      = '0;

        nbytes    = bytes_per_pixel(r_fmt);
        shamt     = {r_byte_pos, 3'b000};
        pix_value = {8'b0, r_accum} | ({24'b0, r_in_byte} << shamt);
        want      = 8'd1;
        count     = 8'd1;
        col_sum   = '0;
        col_wrap  = '0;
        fits_row  = 1'b0;
        fits_next = 1'b0;
        lin_pos   = r_prod_pos + {17'b0, r_col};
        total_ext = {1'b0, r_prod_total};

        if (div_rsp.done) begin
            n_rows = r_rows + div_rsp.quotient;
            n_col  = div_rsp.remainder;
        end

        if (rc_sub_en) begin
            n_remaining = (total_ext > lin_pos) ? REMAIN_W'(total_ext - lin_pos) : '0;
        end

        if (proc && !r_finished) begin
            if (r_rle && r_expect_hdr) begin
                n_run        = r_in_byte[HDR_RUN_BIT];
                n_pix_left   = {1'b0, r_in_byte[HDR_RUN_BIT-1:0]} + 8'd1;
                n_expect_hdr = 1'b0;
                n_byte_pos   = '0;
                n_accum      = '0;
            end else if (({1'b0, r_byte_pos} + 3'd1) < nbytes) begin
                n_accum    = r_accum | ({16'b0, r_in_byte} << shamt);
                n_byte_pos = r_byte_pos + 2'd1;
            end else begin
                n_byte_pos = '0;
                n_accum    = '0;
                if (r_rle && r_run) begin
                    want         = (r_pix_left != '0) ? r_pix_left : 8'd1;
                    n_pix_left   = '0;
                    n_expect_hdr = 1'b1;
                end else if (r_rle) begin
                    if (r_pix_left <= 8'd1) begin
                        n_pix_left   = '0;
                        n_expect_hdr = 1'b1;
                    end else begin
                        n_pix_left = r_pix_left - 8'd1;
                    end
                end

                if (r_remaining == '0) begin
                    n_finished = 1'b1;
                end else begin
                    count = ({24'b0, want} > r_remaining) ? r_remaining[COUNT_W-1:0] : want;
                    n_out_load  = 1'b1;
                    n_out_pixel = pix_value;
                    n_out_count = count;
                    n_out_col   = r_col;
                    n_out_row   = r_top ? r_rows[COORD_W-1:0]
                                        : (r_height - 16'd1 - r_rows[COORD_W-1:0]);
                    n_out_last  = ({24'b0, count} == r_remaining);
                    n_remaining = r_remaining - {24'b0, count};
                    if (n_out_last) begin
                        n_finished = 1'b1;
                    end

                    // Advance the position; more than one row boundary needs the divider.
                    col_sum   = {1'b0, r_col} + {9'b0, count};
                    fits_row  = col_sum < {1'b0, r_width};
                    col_wrap  = col_sum - {1'b0, r_width};
                    fits_next = col_wrap < {1'b0, r_width};
                    if (fits_row) begin
                        n_col = col_sum[COORD_W-1:0];
                    end else if (fits_next) begin
                        n_col  = col_wrap[COORD_W-1:0];
                        n_rows = r_rows + 17'd1;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = col_sum;
                        div_req.divisor  = r_width;
                    end
                end
            end
        end

        if (n_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle        <= 1'b0;
            r_fmt        <= FMT_ONE_BYTE;
            r_width      <= 16'd1;
            r_height     <= 16'd1;
            r_top        <= 1'b0;
            r_expect_hdr <= 1'b1;
            r_run        <= 1'b0;
            r_pix_left   <= '0;
            r_byte_pos   <= '0;
            r_accum      <= '0;
            r_col        <= '0;
            r_rows       <= '0;
            r_finished   <= 1'b0;
            r_remaining  <= 32'd1;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_RLE_ENABLED:     r_rle    <= i_cfg_data[0];
                    CFG_PIXEL_FORMAT:    r_fmt    <= i_cfg_data[1:0];
                    CFG_IMAGE_WIDTH:     r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT:    r_height <= i_cfg_data;
                    CFG_TOP_LEFT_ORIGIN: r_top    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_expect_hdr <= n_expect_hdr;
            r_run        <= n_run;
            r_pix_left   <= n_pix_left;
            r_byte_pos   <= n_byte_pos;
            r_accum      <= n_accum;
            r_col        <= n_col;
            r_rows       <= n_rows;
            r_finished   <= n_finished;
            r_remaining  <= n_remaining;
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_s_axis_tdata;
        end
        r_out_pixel <= n_out_pixel;
        r_out_count <= n_out_count;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_last  <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_row, r_out_col, r_out_count, r_out_pixel};
    assign o_m_axis_tlast  = r_out_last;

    // Once the image is complete, no further group may be produced.
    a_no_beat_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && !r_out_valid) |=> !r_out_valid)
        else $error("group produced after the last pixel of the image");

    // A group never carries zero pixels.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[39:32] != 8'd0))
        else $error("group with zero repeat count");

    // A group that ends the image leaves the decoder finished.
    a_last_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_load && n_out_last) |=> r_finished)
        else $error("image end reported but decoder not finished");

    // A register write always restarts the remaining-count recompute.
    a_cfg_starts_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (r_rc_state == RC_MUL))
        else $error("register write did not start the recompute");

    // No byte is decoded while the divider is still folding the position.
    a_no_proc_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !proc)
        else $error("byte decoded while the position divider was busy");

endmodule

`default_nettype wire

FILE: hw/rtl/tgarle_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module tgarle_div
    import tgarle_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_rem;
    logic [ROWS_W-1:0]    r_quo;
    logic [COORD_W-1:0]   r_div;

    logic [COORD_W:0]   shifted;
    logic               ge;
    logic [COORD_W:0]   diff;
    logic [COORD_W-1:0] n_rem;
    logic [ROWS_W-1:0]  n_quo;
    logic               last_step;

    always_comb begin
        shifted   = {r_rem, r_quo[ROWS_W-1]};
        ge        = shifted >= {1'b0, r_div};
        diff      = shifted - {1'b0, r_div};
        n_rem     = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
        n_quo     = {r_quo[ROWS_W-2:0], ge};
        last_step = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // The final quotient bit and remainder are presented in the last step cycle.
    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = last_step;
    assign o_rsp.quotient  = n_quo;
    assign o_rsp.remainder = n_rem;

endmodule

`default_nettype wire

FILE: verif/tga_rle_pixel_decoder_unit_tb.sv
// Self-checking testbench for the TGA pixel-data decoder: directed and random byte streams against a predictor.
module tga_rle_pixel_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam int unsigned    WATCHDOG_LIMIT = 2000;
    // Covers output latency, the serial divider and the register recompute.
    localparam int unsigned    SETTLE_CYCLES  = 40;
    localparam int unsigned    RANDOM_BYTES   = 1850;
    localparam int unsigned    REPORT_CAP     = 200;
    // Unlisted format code; the block reads it as four bytes per pixel.
    localparam logic [1:0]     FMT_RESERVED   = 2'd3;

    typedef struct {
        logic [PIXEL_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
    } pixel_group_t;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]     i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    t_cfg_index            i_cfg_index     = CFG_RLE_ENABLED;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_cfg_ready;

    logic [BYTE_W-1:0] byte_q[$];
    pixel_group_t      group_q[$];
    pixel_group_t      head;

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned groups_seen  = 0;
    int unsigned cfg_writes   = 0;
    int unsigned err_count    = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned quiet_cycles = 0;
    bit          calm         = 1'b0;

    // Register copies and decoder state, at their reset values.
    bit                 cfg_rle     = 1'b0;
    logic [1:0]         cfg_fmt     = FMT_ONE_BYTE;
    logic [COORD_W-1:0] cfg_width   = 16'd1;
    logic [COORD_W-1:0] cfg_height  = 16'd1;
    bit                 cfg_topdown = 1'b0;
    bit                 hdr_wait    = 1'b1;
    bit                 in_run      = 1'b0;
    bit                 image_over  = 1'b0;
    int unsigned        pkt_left    = 0;
    logic [1:0]         byte_idx    = '0;
    logic [ACCUM_W-1:0] partial     = '0;
    logic [COORD_W-1:0] col_now     = '0;
    logic [ROWS_W-1:0]  row_now     = '0;

    tga_rle_pixel_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Places a group at the current linear position, clipped to the pixels that remain.
    function automatic void place_group(logic [PIXEL_W-1:0] value, int unsigned want);
        longint unsigned wid, total, pos, left, cnt;
        pixel_group_t    g;
        wid   = cfg_width;
        total = wid * cfg_height;
        pos   = row_now * wid + col_now;
        left  = (pos < total) ? total - pos : 0;
        if (left == 0 || want == 0) begin
            if (left == 0) image_over = 1'b1;
            return;
        end
        cnt      = (want > left) ? left : want;
        g.value  = value;
        g.count  = cnt[COUNT_W-1:0];
        g.column = col_now;
        g.row    = cfg_topdown ? row_now[COORD_W-1:0]
                               : cfg_height - 16'd1 - row_now[COORD_W-1:0];
        g.last   = (cnt == left);
        group_q.push_back(g);
        pos += cnt;
        row_now = ROWS_W'(pos / wid);
        col_now = COORD_W'(pos % wid);
        if (g.last) image_over = 1'b1;
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b);
        int unsigned        pix_bytes;
        int unsigned        want;
        logic [PIXEL_W-1:0] value;
        if (image_over) return;
        if (cfg_rle && hdr_wait) begin
            in_run   = b[HDR_RUN_BIT];
            pkt_left = int'(b[6:0]) + 1;
            hdr_wait = 1'b0;
            byte_idx = '0;
            partial  = '0;
            return;
        end
        case (cfg_fmt)
            FMT_ONE_BYTE:   pix_bytes = 1;
            FMT_THREE_BYTE: pix_bytes = 3;
            default:        pix_bytes = 4;
        endcase
        if (byte_idx + 1 < pix_bytes) begin
            partial  = partial | (ACCUM_W'(b) << (8 * byte_idx));
            byte_idx = byte_idx + 2'd1;
            return;
        end
        value    = {8'h00, partial} | (PIXEL_W'(b) << (8 * byte_idx));
        byte_idx = '0;
        partial  = '0;
        if (!cfg_rle) begin
            want = 1;
        end else if (in_run) begin
            want     = (pkt_left != 0) ? pkt_left : 1;
            pkt_left = 0;
            hdr_wait = 1'b1;
        end else begin
            want = 1;
            if (pkt_left <= 1) begin
                pkt_left = 0;
                hdr_wait = 1'b1;
            end else begin
                pkt_left--;
            end
        end
        place_group(value, want);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    function automatic void push_byte(logic [BYTE_W-1:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    task automatic settle(int unsigned extra);
        while (bytes_taken != bytes_queued || group_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RLE_ENABLED:     cfg_rle     = val[0];
            CFG_PIXEL_FORMAT:    cfg_fmt     = val[1:0];
            CFG_IMAGE_WIDTH:     cfg_width   = val;
            CFG_IMAGE_HEIGHT:    cfg_height  = val;
            CFG_TOP_LEFT_ORIGIN: cfg_topdown = val[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Byte driver: feeds accepted bytes to the predictor and pops pending bytes, inserting random gaps between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_byte(i_s_axis_tdata);
                bytes_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= byte_q.pop_front();
                    send_gap = pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Group monitor with random backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                groups_seen++;
                if (group_q.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_CAP)
                        $display("%0t ns: unexpected pixel group, expected none, got tdata 0x%0h",
                                 $time, o_m_axis_tdata);
                end else begin
                    head = group_q.pop_front();
                    check_field("pixel_value", head.value, o_m_axis_tdata[PIXEL_W-1:0]);
                    check_field("repeat_count", head.count,
                                o_m_axis_tdata[PIXEL_W+COUNT_W-1:PIXEL_W]);
                    check_field("start_column", head.column,
                                o_m_axis_tdata[PIXEL_W+COUNT_W+COORD_W-1:PIXEL_W+COUNT_W]);
                    check_field("start_row", head.row,
                                o_m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-COORD_W]);
                    check_field("image_done", head.last, o_m_axis_tlast);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("tga_rle_pixel_decoder_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned     r, target, phase_bytes, n, nb, k, settings;
        int unsigned     random_bytes;
        longint unsigned budget, need, w, h;
        bit              rle, run;
        logic [1:0]      fmt;

        random_bytes = 0;
        settings     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One wide row, four-byte pixels, bottom-up storage.
        write_reg(CFG_RLE_ENABLED, 16'd1);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_FOUR_BYTE));
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        write_reg(CFG_TOP_LEFT_ORIGIN, 16'd0);
        settings++;
        push_byte(8'hFF);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h00);
        repeat (4) push_byte(8'h00);
        // Open a full literal packet and leave a pixel half built.
        push_byte(8'h7F);
        push_byte(8'h11);
        push_byte(8'h22);

        // Narrowing to one column puts the position far past the row end.
        settle(SETTLE_CYCLES);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_ONE_BYTE));
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(CFG_TOP_LEFT_ORIGIN, 16'd1);
        settings++;
        push_byte(8'h33);
        push_byte(8'h44);
        push_byte(8'h55);

        // Raw mode with the literal packet still open.
        settle(SETTLE_CYCLES);
        write_reg(CFG_RLE_ENABLED, 16'd0);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_THREE_BYTE));
        settings++;
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        push_byte(8'h80);
        push_byte(8'h81);

        settle(SETTLE_CYCLES);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_RESERVED));
        settings++;
        push_byte(8'h82);
        push_byte(8'h83);

        settle(SETTLE_CYCLES);
        write_reg(CFG_RLE_ENABLED, 16'd1);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_ONE_BYTE));
        settings++;
        push_byte(8'hA5);

        while (random_bytes < RANDOM_BYTES) begin
            settle(SETTLE_CYCLES);
            calm   = ($urandom_range(0, 3) == 0);
            rle    = ($urandom_range(0, 9) < 7);
            r      = $urandom_range(0, 9);
            fmt    = (r < 4) ? FMT_ONE_BYTE : (r < 7) ? FMT_THREE_BYTE :
                     (r < 9) ? FMT_FOUR_BYTE : FMT_RESERVED;
            nb     = (fmt == FMT_ONE_BYTE) ? 1 : (fmt == FMT_THREE_BYTE) ? 3 : 4;
            target = $urandom_range(150, 300);
            r = $urandom_range(0, 99);
            if (r < 20)      w = $urandom_range(1, 8);
            else if (r < 45) w = $urandom_range(9, 300);
            else if (r < 75) w = $urandom_range(301, 8000);
            else if (r < 90) w = $urandom_range(8001, 65534);
            else             w = 65535;
            // Keep enough rows ahead that the image does not end inside this phase.
            budget = longint'(target) * 64 + 4096;
            need   = row_now + (col_now + budget) / w + 2;
            if (need > 65535) begin
                w    = 65535;
                need = row_now + (col_now + budget) / w + 2;
            end
            if (need > 65535) need = 65535;
            h = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(int'(need), 65535);
            write_reg(CFG_RLE_ENABLED, 16'(rle));
            write_reg(CFG_PIXEL_FORMAT, 16'(fmt));
            write_reg(CFG_IMAGE_WIDTH, w[COORD_W-1:0]);
            write_reg(CFG_IMAGE_HEIGHT, h[COORD_W-1:0]);
            write_reg(CFG_TOP_LEFT_ORIGIN, 16'($urandom_range(0, 1)));
            settings++;
            phase_bytes = 0;
            while (phase_bytes < target) begin
                if (rle) begin
                    r = $urandom_range(0, 99);
                    if (r < 40)      n = $urandom_range(1, 4);
                    else if (r < 80) n = $urandom_range(5, 32);
                    else if (r < 95) n = $urandom_range(33, 127);
                    else             n = MAX_PACKET;
                    run = $urandom_range(0, 1);
                    push_byte({run, 7'(n - 1)});
                    k = run ? nb : n * nb;
                    phase_bytes += k + 1;
                    repeat (k) push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_byte(8'($urandom_range(0, 255)));
                    phase_bytes++;
                end
            end
            // Sometimes cut the stream mid-packet or mid-pixel before the next setting.
            if ($urandom_range(0, 2) == 0) begin
                k = $urandom_range(1, 5);
                phase_bytes += k;
                repeat (k) push_byte(8'($urandom_range(0, 255)));
            end
            random_bytes += phase_bytes;
        end

        // Finish on a run that overshoots the last few pixels of the image.
        settle(SETTLE_CYCLES);
        calm = 1'b0;
        write_reg(CFG_RLE_ENABLED, 16'd1);
        write_reg(CFG_PIXEL_FORMAT, 16'(FMT_ONE_BYTE));
        settings++;
        while (!image_over && !(hdr_wait && byte_idx == 0)) begin
            push_byte(8'($urandom_range(0, 255)));
            settle(0);
        end
        settle(SETTLE_CYCLES);
        w = col_now + $urandom_range(2, 10);
        if (w > 65535) w = 65535;
        h = row_now + 1;
        if (h > 65535) h = 65535;
        write_reg(CFG_IMAGE_WIDTH, w[COORD_W-1:0]);
        write_reg(CFG_IMAGE_HEIGHT, h[COORD_W-1:0]);
        write_reg(CFG_TOP_LEFT_ORIGIN, 16'($urandom_range(0, 1)));
        settings++;
        push_byte(8'hFF);
        push_byte(8'($urandom_range(0, 255)));
        // Trailing bytes after the image is complete must be swallowed.
        repeat (6) push_byte(8'($urandom_range(0, 255)));
        settle(SETTLE_CYCLES);

        $display("Streamed %0d bytes (%0d random) across %0d register settings, %0d writes.",
                 bytes_taken, random_bytes, settings, cfg_writes);
        $display("Checked %0d pixel groups in raw and packet modes; image complete: %0d.",
                 groups_seen, image_over);
        if (err_count == 0) begin
            $display("tga_rle_pixel_decoder_unit_tb: PASS");
        end else begin
            $display("tga_rle_pixel_decoder_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
